FILE: rtl/tcgw_pkg.sv
// ----------------------------------------------------------------------------
// tcgw_pkg
// Shared types, geometry constants and the 5x7 glyph table of the text
// console glyph writer.
// ----------------------------------------------------------------------------
package tcgw_pkg;

   localparam int LINE_BYTES       = 64;
   localparam int CONSOLE_LINES_PX = 336;

   localparam int X_W        = $clog2(LINE_BYTES * 8);
   localparam int Y_W        = $clog2(CONSOLE_LINES_PX + 1);
   localparam int X_WRAP     = LINE_BYTES * 8 - 6;
   localparam int CHAR_ADV   = 6;
   localparam int TEXT_LINE  = 8;

   localparam int ADDR_W     = 24;
   localparam int MASK_W     = 16;
   localparam int CHAR_W     = 7;
   localparam int GLYPHS     = 96;
   localparam int CODE_W     = $clog2(GLYPHS);
   localparam int GLYPH_COLS = 5;
   localparam int GLYPH_ROWS = 7;

   localparam logic [ADDR_W-1:0] FRAME_BASE_RESET = 24'h3FA700;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'd10;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'd32;

   localparam logic       OP_PRINT = 1'b0;
   localparam logic       OP_CLEAR = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // last step of a job: the scroll result
   localparam logic [2:0] STEP_SCROLL = 3'd7;
   localparam logic [2:0] STEP_LAST_ROW = 3'(GLYPH_ROWS - 1);

   typedef enum logic [1:0] {
      KIND_CLEAR_BITS = 2'd0,
      KIND_SCROLL     = 2'd1,
      KIND_FILL       = 2'd2
   } kind_type;

   typedef struct packed {
      logic              clear;
      logic              draw;
      logic              scroll;
      logic [CODE_W-1:0] code;
      logic [X_W-1:0]    x;
      logic [Y_W-1:0]    y;
   } job_type;

   // one word per glyph, column 0 in the top byte; bit r of a column is row r
   localparam logic [39:0] FONT_GLYPH [GLYPHS] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
      40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
      40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
      40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
      40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
      40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
      40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
      40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
      40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
      40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808
   };

endpackage

FILE: rtl/tcgw_front.sv
// ----------------------------------------------------------------------------
// tcgw_front
// Accepts items, keeps the pixel cursor and turns each item into at most one
// job for the back end.
// ----------------------------------------------------------------------------
module tcgw_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic                        req_op,
   input  logic [tcgw_pkg::CHAR_W-1:0] req_char,
   input  logic                        queue_full,
   output logic                        push,
   output tcgw_pkg::job_type           push_job
);
   import tcgw_pkg::*;

   logic [X_W-1:0] cursor_x_ff, cursor_x_in;
   logic [Y_W-1:0] cursor_y_ff, cursor_y_in;

   logic           accept;
   logic           is_clear, is_newline, is_print, draw, wrap, do_newline, scroll;
   logic [X_W-1:0] x_adv;
   logic [Y_W-1:0] y_next_line;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      is_clear    = (req_op == OP_CLEAR);
      is_newline  = !is_clear && (req_char == CHAR_NEWLINE);
      is_print    = !is_clear && !is_newline;
      // codes below space other than newline act as space
      draw        = is_print && (req_char > CHAR_SPACE);
      x_adv       = cursor_x_ff + X_W'(CHAR_ADV);
      wrap        = is_print && (x_adv >= X_W'(X_WRAP));
      do_newline  = is_newline || wrap;
      y_next_line = cursor_y_ff + Y_W'(TEXT_LINE);
      scroll      = do_newline && (y_next_line >= Y_W'(CONSOLE_LINES_PX));

      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      if (accept) begin
         if (is_clear) begin
            cursor_x_in = '0;
            cursor_y_in = '0;
         end else if (do_newline) begin
            cursor_x_in = '0;
            cursor_y_in = scroll ? Y_W'(CONSOLE_LINES_PX - TEXT_LINE) : y_next_line;
         end else begin
            cursor_x_in = x_adv;
         end
      end

      push            = accept && (is_clear || draw || scroll);
      push_job.clear  = is_clear;
      push_job.draw   = draw;
      push_job.scroll = scroll;
      push_job.code   = draw ? CODE_W'(req_char - CHAR_SPACE) : '0;
      push_job.x      = cursor_x_ff;
      push_job.y      = cursor_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
      end else begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
      end
   end

endmodule

FILE: rtl/tcgw_queue.sv
// ----------------------------------------------------------------------------
// tcgw_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module tcgw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcgw_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output tcgw_pkg::job_type head_job
);
   import tcgw_pkg::*;

   job_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]      count_ff, count_in;

   assign full       = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/tcgw_back.sv
// ----------------------------------------------------------------------------
// tcgw_back
// Expands one job into its results, one a cycle while the receiver is ready, into the output register.
// ----------------------------------------------------------------------------
module tcgw_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tcgw_pkg::ADDR_W-1:0] frame_base,
   input  logic                        head_valid,
   input  tcgw_pkg::job_type           head_job,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [1:0]                  rsp_kind,
   output logic [tcgw_pkg::ADDR_W-1:0] rsp_addr,
   output logic [tcgw_pkg::MASK_W-1:0] rsp_mask,
   output logic                        rsp_last
);
   import tcgw_pkg::*;

   job_type           job_ff, job_in;
   logic              job_valid_ff, job_valid_in;
   logic [39:0]       glyph_ff, glyph_in;
   logic [2:0]        step_ff, step_in;

   logic              out_valid_ff, out_valid_in;
   kind_type          out_kind_ff, cur_kind;
   logic [ADDR_W-1:0] out_addr_ff, cur_addr;
   logic [MASK_W-1:0] out_mask_ff, cur_mask;
   logic              out_last_ff, cur_last;

   logic              advance, emit, cur_is_row;
   logic [Y_W-1:0]    row_y;
   logic [2:0]        sub;
   logic [3:0]        bit_pos;

   always_comb begin
      cur_is_row = job_ff.draw && (step_ff != STEP_SCROLL);
      row_y      = job_ff.y + Y_W'(step_ff);
      sub        = job_ff.x[2:0];
      cur_mask   = '0;
      for (int c = 0; c < GLYPH_COLS; c++) begin
         bit_pos = 4'(15 - int'(sub) - c);
         if (glyph_ff[32 - 8 * c + int'(step_ff)]) begin
            cur_mask[bit_pos] = 1'b1;
         end
      end
      if (job_ff.clear) begin
         cur_kind = KIND_FILL;
         cur_addr = frame_base;
         cur_mask = '0;
         cur_last = 1'b1;
      end else if (cur_is_row) begin
         cur_kind = KIND_CLEAR_BITS;
         cur_addr = frame_base + ADDR_W'(job_ff.x >> 3)
                  + ADDR_W'(32'(row_y) * LINE_BYTES);
         cur_last = (step_ff == STEP_LAST_ROW) && !job_ff.scroll;
      end else begin
         cur_kind = KIND_SCROLL;
         cur_addr = frame_base;
         cur_mask = '0;
         cur_last = 1'b1;
      end
   end

   always_comb begin
      advance      = !out_valid_ff || rsp_tready;
      emit         = advance && job_valid_ff;
      pop          = head_valid && (!job_valid_ff || (emit && cur_last));
      out_valid_in = advance ? job_valid_ff : out_valid_ff;

      job_in       = job_ff;
      glyph_in     = glyph_ff;
      step_in      = step_ff;
      job_valid_in = job_valid_ff;
      if (pop) begin
         job_in       = head_job;
         glyph_in     = FONT_GLYPH[head_job.code];
         step_in      = head_job.draw ? 3'd0 : STEP_SCROLL;
         job_valid_in = 1'b1;
      end else if (emit) begin
         step_in = step_ff + 3'd1;
         if (cur_last) begin
            job_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      glyph_ff <= glyph_in;
      step_ff  <= step_in;
      if (emit) begin
         out_kind_ff <= cur_kind;
         out_addr_ff <= cur_addr;
         out_mask_ff <= cur_mask;
         out_last_ff <= cur_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_addr   = out_addr_ff;
   assign rsp_mask   = out_mask_ff;
   assign rsp_last   = out_last_ff;

`ifndef SYNTHESIS
   a_fill_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_kind_ff != KIND_CLEAR_BITS) |-> out_last_ff)
      else $error("scroll or fill result not marked last");
   a_mask_only_rows: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_kind_ff != KIND_CLEAR_BITS) |-> (out_mask_ff == '0))
      else $error("non-row result carries a mask");
   a_pop_loads_job: assert property (@(posedge clock) disable iff (reset)
      pop |=> job_valid_ff)
      else $error("job not held after pop");
   a_no_pop_mid_job: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && !(emit && cur_last) |-> !pop)
      else $error("queue popped while a job is still running");
`endif

endmodule

FILE: rtl/text_console_glyph_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_glyph_writer_unit
// Text console that turns characters into 1-bpp framebuffer write commands.
//
// req_ channel: one item per character or clear command. rsp_ channel: the
// framebuffer commands, tlast on the final one caused by an item. csr_
// channel: writes frame_base, always ready; write only while idle.
// A printable character gives seven row results, plus a scroll when the
// cursor wraps off the bottom line; space, newline and other control codes
// give nothing or one scroll; clear gives one fill result.
// The first result of an item passes through the job queue, the back end's job
// register and the output register. Throughput: one result per cycle while
// rsp_tready is high; an item with no result is taken by the front end alone
// and pushes no job. A four-deep job queue lets the front keep accepting
// while the back end works or the receiver stalls; when rsp_tready is low the
// output register holds and, once the queue fills, req_tready drops. Reset
// homes the cursor, empties the queue and restores frame_base.
// ----------------------------------------------------------------------------
module text_console_glyph_writer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [6:0] character, [7] zero
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [23:0] address, [39:24] clear_mask
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_wdata    // [23:0] frame_base
);
   import tcgw_pkg::*;

   logic [ADDR_W-1:0] frame_base_ff, frame_base_in;
   logic              push, pop, queue_full, head_valid;
   job_type           push_job, head_job;
   logic [ADDR_W-1:0] rsp_addr;
   logic [MASK_W-1:0] rsp_mask;

   assign csr_ready     = 1'b1;
   assign frame_base_in = (csr_valid && csr_ready) ? csr_wdata : frame_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff <= FRAME_BASE_RESET;
      end else begin
         frame_base_ff <= frame_base_in;
      end
   end

   tcgw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_char   (req_tdata[CHAR_W-1:0]),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   tcgw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   tcgw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .frame_base (frame_base_ff),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_addr   (rsp_addr),
      .rsp_mask   (rsp_mask),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {rsp_mask, rsp_addr};

endmodule

FILE: tb/sv/text_console_glyph_writer_unit_tb.sv
// ----------------------------------------------------------------------------
// text_console_glyph_writer_unit_tb
// Self-checking bench for the text console glyph writer. A queue-fed driver
// sends characters and clear commands, and a monitor predicts the framebuffer
// commands for every accepted item and checks each result against them.
// The run goes through several frame_base settings, random stalls on both
// sides, a long receiver hold-off, line wrap and scroll off the bottom line.
// ----------------------------------------------------------------------------
module text_console_glyph_writer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tcgw_pkg::*;

   localparam int LONG_HOLD = 300;

   typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_type;

   typedef struct {
      logic              op;
      logic [CHAR_W-1:0] ch;
   } console_item_type;

   typedef struct packed {
      kind_type          kind;
      logic [ADDR_W-1:0] addr;
      logic [MASK_W-1:0] mask;
      logic              last;
   } fb_cmd_type;

   // 5x7 glyphs for codes 0x20 up, column 0 in the top byte, bit r = row r
   localparam logic [39:0] FONT_COLUMNS [96] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
      40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
      40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
      40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
      40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
      40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
      40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
      40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
      40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
      40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [6:0] character, [7] zero
   logic        req_tuser = 1'b0;  // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [23:0] address, [39:24] clear_mask
   logic [1:0]  rsp_tuser;         // [1:0] kind
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [23:0] csr_wdata = '0;    // [23:0] frame_base

   // console model state
   logic [ADDR_W-1:0] base_addr;
   int unsigned       pen_x;
   int unsigned       pen_y;

   console_item_type items_to_send[$];
   fb_cmd_type       fb_cmds_due[$];
   int unsigned      fail_count = 0;

   idle_mode_type send_mode = IDLE_NONE;
   idle_mode_type recv_mode = IDLE_NONE;
   int unsigned   gap_left = 0;
   int unsigned   stall_left = 0;
   int unsigned   hold_left = 0;
   bit            hold_req = 1'b0;
   bit            req_taken = 1'b0;
   bit            rsp_taken = 1'b0;

   text_console_glyph_writer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int unsigned draw_wait(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:   return 0;
         IDLE_SPARSE: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 18) : 0;
         default:     return $urandom_range(0, 18);
      endcase
   endfunction

   function automatic fb_cmd_type make_cmd(input kind_type kind,
                                           input logic [ADDR_W-1:0] addr,
                                           input logic [MASK_W-1:0] mask);
      fb_cmd_type c;
      c.kind = kind;
      c.addr = addr;
      c.mask = mask;
      c.last = 1'b0;
      return c;
   endfunction

   // returns 1 when the move runs off the bottom and the screen scrolls
   function automatic bit line_feed();
      pen_x = 0;
      pen_y += TEXT_LINE;
      if (pen_y >= CONSOLE_LINES_PX) begin
         pen_y = CONSOLE_LINES_PX - TEXT_LINE;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic render_item(input logic op, input logic [CHAR_W-1:0] ch);
      fb_cmd_type  cmds[$];
      fb_cmd_type  c;
      logic [39:0] cols;
      logic [15:0] mask;
      int unsigned sub;
      int unsigned addr;
      int          row;
      int          col;
      if (op == OP_CLEAR) begin
         cmds.push_back(make_cmd(KIND_FILL, base_addr, '0));
         pen_x = 0;
         pen_y = 0;
      end else if (ch == CHAR_NEWLINE) begin
         if (line_feed())
            cmds.push_back(make_cmd(KIND_SCROLL, base_addr, '0));
      end else begin
         // control codes other than newline draw nothing, like space
         if (ch > CHAR_SPACE) begin
            cols = FONT_COLUMNS[ch - CHAR_SPACE];
            sub  = pen_x & 7;
            for (row = 0; row < GLYPH_ROWS; row++) begin
               mask = '0;
               for (col = 0; col < GLYPH_COLS; col++)
                  if (cols[32 - 8*col + row])
                     mask[15 - sub - col] = 1'b1;
               addr = base_addr + (pen_x >> 3) + (pen_y + row) * LINE_BYTES;
               cmds.push_back(make_cmd(KIND_CLEAR_BITS, addr[ADDR_W-1:0], mask));
            end
         end
         pen_x += CHAR_ADV;
         if (pen_x >= X_WRAP && line_feed())
            cmds.push_back(make_cmd(KIND_SCROLL, base_addr, '0));
      end
      foreach (cmds[i]) begin
         c = cmds[i];
         c.last = (i == cmds.size() - 1);
         fb_cmds_due.push_back(c);
      end
   endtask

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      console_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!req_tvalid || req_taken) begin
         if (req_tvalid)
            gap_left = draw_wait(send_mode);
         if (gap_left > 0 || items_to_send.size() == 0) begin
            if (gap_left > 0)
               gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            it = items_to_send.pop_front();
            req_tdata  <= {1'b0, it.ch};
            req_tuser  <= it.op;
            req_tvalid <= 1'b1;
         end
      end
   end

   // receiver: a stall drawn per result, plus the long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
         end
         if (rsp_taken)
            stall_left = draw_wait(recv_mode);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor: samples handshakes on the rising edge
   always @(posedge clock) begin
      fb_cmd_type want;
      req_taken = !reset && req_tvalid && req_tready;
      rsp_taken = !reset && rsp_tvalid && rsp_tready;
      if (!reset && csr_valid && csr_ready)
         base_addr = csr_wdata;
      if (rsp_taken) begin
         if (fb_cmds_due.size() == 0) begin
            $write("%0t ns: unexpected result: expected none, ", $time);
            $display("got kind=%0d addr=%06h mask=%04h last=%0b",
                     rsp_tuser, rsp_tdata[23:0], rsp_tdata[39:24], rsp_tlast);
            fail_count++;
         end else begin
            want = fb_cmds_due.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata[23:0] !== want.addr ||
                rsp_tdata[39:24] !== want.mask || rsp_tlast !== want.last) begin
               $write("%0t ns: mismatch: expected kind=%0d addr=%06h mask=%04h last=%0b, ",
                      $time, want.kind, want.addr, want.mask, want.last);
               $display("got kind=%0d addr=%06h mask=%04h last=%0b",
                        rsp_tuser, rsp_tdata[23:0], rsp_tdata[39:24], rsp_tlast);
               fail_count++;
            end
         end
      end
      if (req_taken)
         render_item(req_tuser, req_tdata[CHAR_W-1:0]);
   end

   task automatic queue_item(input logic op, input logic [CHAR_W-1:0] ch);
      console_item_type it;
      it.op = op;
      it.ch = ch;
      items_to_send.push_back(it);
   endtask

   function automatic logic [CHAR_W-1:0] printable_char();
      return CHAR_W'($urandom_range(33, 127));
   endfunction

   // codes that only move the cursor: space and non-newline control codes
   function automatic logic [CHAR_W-1:0] blank_char();
      logic [CHAR_W-1:0] ch;
      ch = CHAR_W'($urandom_range(0, 32));
      return (ch == CHAR_NEWLINE) ? CHAR_SPACE : ch;
   endfunction

   // idle: nothing left to send and every expected result seen, then a
   // settling wait for an item with no result that may still be in flight
   task automatic wait_idle();
      do @(negedge clock);
      while (items_to_send.size() != 0 || req_tvalid || fb_cmds_due.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_frame_base(input logic [ADDR_W-1:0] value);
      @(negedge clock);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      base_addr = FRAME_BASE_RESET;
      pen_x     = 0;
      pen_y     = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: glyph extremes, blank glyphs, controls, newline, clear
      send_mode = IDLE_NONE;
      recv_mode = IDLE_NONE;
      queue_item(OP_CLEAR, 7'h00);
      queue_item(OP_PRINT, 7'h41);
      queue_item(OP_PRINT, 7'h21);
      queue_item(OP_PRINT, 7'h7F);
      queue_item(OP_PRINT, 7'h7E);
      queue_item(OP_PRINT, CHAR_SPACE);
      queue_item(OP_PRINT, 7'h00);
      queue_item(OP_PRINT, 7'h1F);
      queue_item(OP_PRINT, CHAR_NEWLINE);
      queue_item(OP_PRINT, 7'h5F);
      queue_item(OP_CLEAR, 7'h7F);
      queue_item(OP_PRINT, 7'h2E);
      wait_idle();

      // home, run down to the bottom line, then one scroll by newline
      write_frame_base(ADDR_W'($urandom()));
      send_mode = IDLE_FULL;
      recv_mode = IDLE_FULL;
      queue_item(OP_CLEAR, CHAR_W'($urandom_range(0, 127)));
      repeat (42) queue_item(OP_PRINT, CHAR_NEWLINE);
      wait_idle();

      // top of the address space: row addresses wrap around; the receiver
      // holds off while the sender keeps going, so the input backs up
      write_frame_base(24'hFFFFFF);
      send_mode = IDLE_NONE;
      recv_mode = IDLE_SPARSE;
      @(posedge clock);
      hold_req = 1'b1;
      repeat (24) queue_item(OP_PRINT, printable_char());
      wait_idle();

      // fill the bottom line, then wrap a glyph off its end: rows plus scroll
      write_frame_base(FRAME_BASE_RESET);
      send_mode = IDLE_FULL;
      recv_mode = IDLE_FULL;
      repeat (60) begin
         if ($urandom_range(0, 1) == 0)
            queue_item(OP_PRINT, printable_char());
         else
            queue_item(OP_PRINT, blank_char());
      end
      queue_item(OP_PRINT, printable_char());
      wait_idle();

      repeat (12) @(negedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: sim.f
rtl/tcgw_pkg.sv
rtl/tcgw_front.sv
rtl/tcgw_queue.sv
rtl/tcgw_back.sv
rtl/text_console_glyph_writer_unit.sv
tb/sv/text_console_glyph_writer_unit_tb.sv
